/* sv/tst_pkg.sv */
`default_nettype none
package tst_pkg;

  localparam int TOPIC_SLOTS_DEF = 16;
  localparam int SUBS_PER_TOPIC_DEF = 16;
  localparam int CLIENT_ID_BITS_DEF = 8;
  localparam int KEY_BITS_DEF = 64;

  typedef enum logic [1:0] {
    OP_SUBSCRIBE   = 2'd0,
    OP_UNSUBSCRIBE = 2'd1,
    OP_PUBLISH     = 2'd2,
    OP_DISCONNECT  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_SUBSCRIBED     = 4'd0,
    ST_ALREADY        = 4'd1,
    ST_TOO_MANY       = 4'd2,
    ST_FULL           = 4'd3,
    ST_UNSUBSCRIBED   = 4'd4,
    ST_NOT_SUBSCRIBED = 4'd5,
    ST_DELIVER        = 4'd6,
    ST_NO_TOPIC       = 4'd7,
    ST_PUB_DONE       = 4'd8,
    ST_DISC_DONE      = 4'd9
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  client_id;
    logic [63:0] topic_key;
  } req_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] dest_client;
    logic [3:0] topic_index;
    logic       last;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_KEY_RD,
    S_KEY_CMP,
    S_SUB_RD,
    S_SUB_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_NEXT_SLOT,
    S_EMIT,
    S_WAIT
  } state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load_req;
    logic clr_slot;
    logic inc_slot;
    logic clr_pos;
    logic inc_pos;
    logic key_rd;
    logic sub_rd;
    logic new_topic;
    logic append;
    logic shift_wr;
    logic dec_count;
    logic emit;
    logic [3:0] emit_status;
    logic emit_deliver;
    logic emit_zero_slot;
    logic emit_last;
  } cmd_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic slot_in_range;
    logic key_hit;
    logic pos_in_range;
    logic sub_hit;
    logic sub_is_sender;
    logic table_full;
    logic list_full;
    logic shift_more;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

/* sv/tst_datapath.sv */
`default_nettype none
module tst_datapath
  import tst_pkg::*;
#(
  parameter int TOPIC_SLOTS    = TOPIC_SLOTS_DEF,
  parameter int SUBS_PER_TOPIC = SUBS_PER_TOPIC_DEF,
  parameter int CLIENT_ID_BITS = CLIENT_ID_BITS_DEF,
  parameter int KEY_BITS       = KEY_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t req,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output rsp_t      rsp,
  output logic      rsp_valid,
  input  wire logic rsp_ready
);

  localparam int SW = $clog2(TOPIC_SLOTS + 1);
  localparam int SI = (TOPIC_SLOTS > 1) ? $clog2(TOPIC_SLOTS) : 1;
  localparam int PW = $clog2(SUBS_PER_TOPIC + 1);
  localparam int PI = (SUBS_PER_TOPIC > 1) ? $clog2(SUBS_PER_TOPIC) : 1;
  localparam int AW = SI + PI;

  logic [KEY_BITS-1:0]       key_mem [TOPIC_SLOTS];
  logic [CLIENT_ID_BITS-1:0] sub_mem [2**AW];
  logic [PW-1:0]             counts [TOPIC_SLOTS];
  logic [SW-1:0]             in_use;

  logic [1:0]                op;
  logic [CLIENT_ID_BITS-1:0] client;
  logic [KEY_BITS-1:0]       key;
  logic [SW-1:0]             slot;
  logic [PW-1:0]             pos;
  logic [KEY_BITS-1:0]       key_rd;
  logic [CLIENT_ID_BITS-1:0] sub_rd;
  logic [PW-1:0]             cnt;

  logic [SI-1:0] slot_ix;
  logic [PI-1:0] pos_ix;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  assign slot_ix = slot[SI-1:0];
  assign pos_ix  = pos[PI-1:0];
  assign cnt     = counts[slot_ix];
  assign rd_addr = {slot_ix, pos_ix};

  always_comb begin
    wr_addr = {slot_ix, pos_ix};
    if (cmd.shift_wr && pos != '0) begin
      wr_addr = {slot_ix, PI'(pos - PW'(1))};
    end else if (cmd.append) begin
      wr_addr = {slot_ix, cnt[PI-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_rd) begin
      key_rd <= key_mem[slot_ix];
    end
    if (cmd.sub_rd) begin
      sub_rd <= sub_mem[rd_addr];
    end
    if (cmd.new_topic) begin
      key_mem[slot_ix] <= key;
    end
    if (cmd.append) begin
      sub_mem[wr_addr] <= client;
    end else if (cmd.shift_wr) begin
      sub_mem[wr_addr] <= sub_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op     <= req.op;
      client <= req.client_id[CLIENT_ID_BITS-1:0];
      key    <= req.topic_key[KEY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      pos  <= '0;
    end else begin
      if (cmd.clr_slot) begin
        slot <= '0;
      end else if (cmd.inc_slot) begin
        slot <= slot + SW'(1);
      end
      if (cmd.clr_pos) begin
        pos <= '0;
      end else if (cmd.inc_pos) begin
        pos <= pos + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
      for (int i = 0; i < TOPIC_SLOTS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      if (cmd.new_topic) begin
        in_use <= in_use + SW'(1);
        counts[slot_ix] <= '0;
      end else if (cmd.append) begin
        counts[slot_ix] <= cnt + PW'(1);
      end else if (cmd.dec_count) begin
        counts[slot_ix] <= cnt - PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.status      <= cmd.emit_status;
      rsp.dest_client <= 8'(cmd.emit_deliver ? sub_rd : client);
      rsp.topic_index <= cmd.emit_zero_slot ? 4'd0 : 4'(slot);
      rsp.last        <= cmd.emit_last;
    end
  end

  always_comb begin
    sts.op            = op;
    sts.slot_in_range = (slot < in_use) && (slot < SW'(TOPIC_SLOTS));
    sts.key_hit       = (key_rd == key);
    sts.pos_in_range  = (pos < cnt) && (pos < PW'(SUBS_PER_TOPIC));
    sts.sub_hit       = (sub_rd == client);
    sts.sub_is_sender = (sub_rd == client);
    sts.table_full    = (in_use >= SW'(TOPIC_SLOTS));
    sts.list_full     = (cnt >= PW'(SUBS_PER_TOPIC));
    sts.shift_more    = (pos < cnt) && (pos < PW'(SUBS_PER_TOPIC));
    sts.out_busy      = rsp_valid && !rsp_ready;
  end

  ap_count_bound: assert property (@(posedge clk) disable iff (rst)
    in_use <= SW'(TOPIC_SLOTS))
    else $error("topic count exceeds slots");
  ap_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(rsp_valid && !rsp_ready))
    else $error("result overwritten while stalled");
  ap_new_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.new_topic |-> in_use < SW'(TOPIC_SLOTS))
    else $error("topic created in full table");

endmodule
`default_nettype wire

/* sv/tst_ctrl.sv */
`default_nettype none
module tst_ctrl
  import tst_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          cmd.clr_slot = 1'b1;
          state_next   = S_KEY_RD;
        end
      end
      S_KEY_RD: begin
        // Disconnect walks slots directly; others search keys.
        if (!sts.slot_in_range) begin
          if (sts.out_busy) begin
            state_next = S_KEY_RD;
          end else if (sts.op == OP_DISCONNECT) begin
            cmd.emit = 1'b1; cmd.emit_status = ST_DISC_DONE;
            cmd.emit_zero_slot = 1'b1; cmd.emit_last = 1'b1;
            state_next = S_WAIT;
          end else if (sts.op == OP_SUBSCRIBE) begin
            if (sts.table_full) begin
              cmd.emit = 1'b1; cmd.emit_status = ST_TOO_MANY;
              cmd.emit_zero_slot = 1'b1; cmd.emit_last = 1'b1;
              state_next = S_WAIT;
            end else begin
              cmd.new_topic = 1'b1;
              cmd.clr_pos   = 1'b1;
              state_next    = S_SUB_RD;
            end
          end else begin
            cmd.emit = 1'b1;
            cmd.emit_status = (sts.op == OP_PUBLISH) ? ST_NO_TOPIC : ST_NOT_SUBSCRIBED;
            cmd.emit_zero_slot = 1'b1; cmd.emit_last = 1'b1;
            state_next = S_WAIT;
          end
        end else if (sts.op == OP_DISCONNECT) begin
          cmd.clr_pos = 1'b1;
          state_next  = S_SUB_RD;
        end else begin
          cmd.key_rd = 1'b1;
          state_next = S_KEY_CMP;
        end
      end
      S_KEY_CMP: begin
        if (sts.key_hit) begin
          cmd.clr_pos = 1'b1;
          state_next  = S_SUB_RD;
        end else begin
          cmd.inc_slot = 1'b1;
          state_next   = S_KEY_RD;
        end
      end
      S_SUB_RD: begin
        if (sts.pos_in_range) begin
          cmd.sub_rd = 1'b1;
          state_next = S_SUB_CMP;
        end else if (sts.op == OP_DISCONNECT) begin
          state_next = S_NEXT_SLOT;
        end else if (!sts.out_busy) begin
          cmd.emit = 1'b1; cmd.emit_last = 1'b1;
          state_next = S_WAIT;
          case (sts.op)
            OP_SUBSCRIBE: begin
              if (sts.list_full) begin
                cmd.emit_status = ST_FULL;
              end else begin
                cmd.emit_status = ST_SUBSCRIBED;
                cmd.append = 1'b1;
              end
            end
            OP_UNSUBSCRIBE: cmd.emit_status = ST_NOT_SUBSCRIBED;
            default:        cmd.emit_status = ST_PUB_DONE;
          endcase
        end
      end
      S_SUB_CMP: begin
        if (sts.op == OP_PUBLISH) begin
          if (sts.sub_is_sender) begin
            cmd.inc_pos = 1'b1;
            state_next  = S_SUB_RD;
          end else if (!sts.out_busy) begin
            cmd.emit = 1'b1; cmd.emit_status = ST_DELIVER;
            cmd.emit_deliver = 1'b1;
            cmd.inc_pos = 1'b1;
            state_next  = S_SUB_RD;
          end
        end else if (sts.sub_hit) begin
          if (sts.op == OP_SUBSCRIBE) begin
            if (!sts.out_busy) begin
              cmd.emit = 1'b1; cmd.emit_status = ST_ALREADY;
              cmd.emit_last = 1'b1;
              state_next = S_WAIT;
            end
          end else begin
            // Remove: copy each later entry down one place.
            cmd.inc_pos = 1'b1;
            state_next  = S_SHIFT_RD;
          end
        end else begin
          cmd.inc_pos = 1'b1;
          state_next  = S_SUB_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts.shift_more) begin
          cmd.sub_rd = 1'b1;
          state_next = S_SHIFT_WR;
        end else begin
          cmd.dec_count = 1'b1;
          state_next = (sts.op == OP_DISCONNECT) ? S_NEXT_SLOT : S_EMIT;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.inc_pos  = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_NEXT_SLOT: begin
        cmd.inc_slot = 1'b1;
        state_next   = S_KEY_RD;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1; cmd.emit_status = ST_UNSUBSCRIBED;
          cmd.emit_last = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  ap_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> state == S_IDLE)
    else $error("ready outside idle");
  ap_emit_wait: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.emit_last) |=> state == S_WAIT)
    else $error("final result not followed by wait");
  ap_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.append && cmd.shift_wr))
    else $error("two list writes in one cycle");

endmodule
`default_nettype wire

/* sv/topic_subscription_table_top.sv */
`default_nettype none
// Publish/subscribe topic table.
// Requests arrive on the req channel (valid/ready) as one req_t beat holding
// an operation, a client id and a topic key. Results leave on the rsp
// channel as rsp_t beats; every request ends with exactly one beat whose
// last bit is set, and a publish sends one deliver beat per other subscriber
// before it.
// One request is processed at a time. The controller first scans the topic
// keys one slot at a time, reading a key in S_KEY_RD and comparing it in
// S_KEY_CMP, then walks the chosen subscriber list one entry at a time through
// S_SUB_RD and S_SUB_CMP; removal moves each later entry down through
// S_SHIFT_RD and S_SHIFT_WR, and disconnect walks every list in use. The
// single-port key and list memories set this pace.
// Reset clears the topic count and all subscriber counts at once; no
// clearing pass is needed since only written entries are ever read.
// When the receiver stalls, the registered result beat holds and the
// controller waits before producing the next beat; req_ready stays low
// until the final beat has been registered.
module topic_subscription_table_top
  import tst_pkg::*;
#(
  parameter int TOPIC_SLOTS    = TOPIC_SLOTS_DEF,
  parameter int SUBS_PER_TOPIC = SUBS_PER_TOPIC_DEF,
  parameter int CLIENT_ID_BITS = CLIENT_ID_BITS_DEF,
  parameter int KEY_BITS       = KEY_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  cmd_t cmd;
  sts_t sts;

  tst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tst_datapath #(
    .TOPIC_SLOTS    (TOPIC_SLOTS),
    .SUBS_PER_TOPIC (SUBS_PER_TOPIC),
    .CLIENT_ID_BITS (CLIENT_ID_BITS),
    .KEY_BITS       (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
`default_nettype none
// The testbench drives request beats through the table and keeps its own copy of the
// topic table. Every response beat is checked, field by field, against the oldest
// beat that this copy expects.
module testbench;
  import tst_pkg::*;

  localparam int NSLOT = 16;
  localparam int NSUB = 16;
  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  topic_subscription_table_top u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // This is the predictor's own copy of the table.
  logic [63:0] tbl_key [NSLOT];
  logic [7:0]  tbl_sub [NSLOT][NSUB];
  int          tbl_cnt [NSLOT];
  int          tbl_used;

  rsp_t expected_beats[$];
  int   fail_count;
  int   beats_seen;
  int   reqs_sent;
  int   idle_cycles;
  bit   timed_out;

  // The testbench keeps a pool of keys, so that requests often hit topics that
  // already exist.
  logic [63:0] key_pool[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rsp_t mk(status_t s, logic [7:0] d, int slot, bit l);
    rsp_t r;
    r.status = s;
    r.dest_client = d;
    r.topic_index = slot[3:0];
    r.last = l;
    return r;
  endfunction

  function automatic int slot_of(logic [63:0] k);
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic int pos_of(int s, logic [7:0] c);
    for (int j = 0; j < tbl_cnt[s]; j++) begin
      if (tbl_sub[s][j] == c) return j;
    end
    return -1;
  endfunction

  function automatic void drop_entry(int s, int p);
    for (int k = p; k + 1 < tbl_cnt[s]; k++) tbl_sub[s][k] = tbl_sub[s][k + 1];
    tbl_cnt[s]--;
  endfunction

  // This function applies one request to the table copy and queues the beats that it
  // should cause.
  function automatic void predict_request(req_t r);
    int s;
    int p;
    logic [7:0] c;
    c = r.client_id;
    s = slot_of(r.topic_key);
    case (op_t'(r.op))
      OP_SUBSCRIBE: begin
        if (s < 0 && tbl_used >= NSLOT) begin
          expected_beats.push_back(mk(ST_TOO_MANY, c, 0, 1));
        end else begin
          if (s < 0) begin
            s = tbl_used++;
            tbl_key[s] = r.topic_key;
            tbl_cnt[s] = 0;
          end
          if (pos_of(s, c) >= 0) begin
            expected_beats.push_back(mk(ST_ALREADY, c, s, 1));
          end else if (tbl_cnt[s] >= NSUB) begin
            expected_beats.push_back(mk(ST_FULL, c, s, 1));
          end else begin
            tbl_sub[s][tbl_cnt[s]++] = c;
            expected_beats.push_back(mk(ST_SUBSCRIBED, c, s, 1));
          end
        end
      end
      OP_UNSUBSCRIBE: begin
        if (s < 0) begin
          expected_beats.push_back(mk(ST_NOT_SUBSCRIBED, c, 0, 1));
        end else begin
          p = pos_of(s, c);
          if (p < 0) begin
            expected_beats.push_back(mk(ST_NOT_SUBSCRIBED, c, s, 1));
          end else begin
            drop_entry(s, p);
            expected_beats.push_back(mk(ST_UNSUBSCRIBED, c, s, 1));
          end
        end
      end
      OP_PUBLISH: begin
        if (s < 0) begin
          expected_beats.push_back(mk(ST_NO_TOPIC, c, 0, 1));
        end else begin
          for (int j = 0; j < tbl_cnt[s]; j++) begin
            if (tbl_sub[s][j] != c) begin
              expected_beats.push_back(mk(ST_DELIVER, tbl_sub[s][j], s, 0));
            end
          end
          expected_beats.push_back(mk(ST_PUB_DONE, c, s, 1));
        end
      end
      default: begin
        for (int i = 0; i < tbl_used; i++) begin
          p = pos_of(i, c);
          if (p >= 0) drop_entry(i, p);
        end
        expected_beats.push_back(mk(ST_DISC_DONE, c, 0, 1));
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, rsp_t got, rsp_t want);
    $display({"MISMATCH %s: got st=%0d dst=%0d idx=%0d last=%0b, ",
              "want st=%0d dst=%0d idx=%0d last=%0b"},
             what, got.status, got.dest_client, got.topic_index, got.last,
             want.status, want.dest_client, want.topic_index, want.last);
    fail_count++;
  endtask

  // This process checks every response beat as it is accepted.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", rsp, '0);
      end else if (rsp !== expected_beats[0]) begin
        report_mismatch("field", rsp, expected_beats[0]);
        void'(expected_beats.pop_front());
      end else begin
        void'(expected_beats.pop_front());
      end
    end
  end

  // The receiver stalls in a pattern that changes between stalls, long stalls, and
  // stretches in which it is always ready.
  int stall_mode;
  initial begin
    rsp_ready = 1'b0;
    stall_mode = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= ($urandom_range(0, 3) != 0);
        2: rsp_ready <= ($urandom_range(0, 1) != 0);
        default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // The watchdog ends the run after too many cycles in which no beat moves.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  int burst_left;

  // This task sends one request beat. It holds valid across a burst and leaves a random
  // gap after a burst ends.
  task automatic send_req(op_t op, logic [7:0] c, logic [63:0] k);
    req_t r;
    r.op = op;
    r.client_id = c;
    r.topic_key = k;
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_request(r);
    reqs_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // The tests run after a single reset, each on the table that the previous one left.
  // This test covers the extremes of the fields and all four operations on a small table.
  task automatic test_basic_ops();
    logic [63:0] ka;
    logic [63:0] kb;
    ka = 64'hFFFF_FFFF_FFFF_FFFF;
    kb = 64'h0;
    send_req(OP_PUBLISH, 8'd1, ka);        // publish to a topic that does not exist
    send_req(OP_UNSUBSCRIBE, 8'd1, ka);    // unsubscribe from a topic that does not exist
    send_req(OP_DISCONNECT, 8'hFF, ka);    // disconnect a client that is subscribed nowhere
    send_req(OP_SUBSCRIBE, 8'd0, ka);
    send_req(OP_SUBSCRIBE, 8'hFF, ka);
    send_req(OP_SUBSCRIBE, 8'hFF, ka);     // the client is already subscribed
    send_req(OP_SUBSCRIBE, 8'h5A, kb);
    send_req(OP_PUBLISH, 8'h5A, kb);       // the sender is the only subscriber
    send_req(OP_PUBLISH, 8'h33, ka);
    send_req(OP_PUBLISH, 8'hFF, ka);
    send_req(OP_UNSUBSCRIBE, 8'h77, ka);   // the topic exists but the client is not in it
    send_req(OP_UNSUBSCRIBE, 8'd0, ka);
    send_req(OP_SUBSCRIBE, 8'hFF, kb);
    send_req(OP_DISCONNECT, 8'hFF, 64'h0123_4567_89AB_CDEF);
    send_req(OP_PUBLISH, 8'd2, kb);
    drain();
  endtask

  // This test fills one topic's list and the whole topic table.
  task automatic test_full_table();
    for (int i = 0; i < NSUB + 1; i++) send_req(OP_SUBSCRIBE, 8'(i * 15), 64'hA5A5);
    send_req(OP_SUBSCRIBE, 8'd0, 64'hA5A5);  // already subscribed takes priority over topic full
    send_req(OP_PUBLISH, 8'd200, 64'hA5A5);
    for (int i = 0; i < NSLOT; i++) begin
      key_pool.push_back(rand_key());
      send_req(OP_SUBSCRIBE, 8'(i), key_pool[$]);
    end
    drain();
  endtask

  // The random test mostly uses keys and clients that the table already knows, so that
  // lists fill up and publishes fan out.
  task automatic test_random(int n);
    op_t op;
    logic [7:0] c;
    logic [63:0] k;
    for (int i = 0; i < n; i++) begin
      op = op_t'($urandom_range(0, 9) < 5 ? OP_SUBSCRIBE : $urandom_range(1, 3));
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
      if (key_pool.size() == 0 || $urandom_range(0, 7) == 0) k = rand_key();
      else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (key_pool.size() < 12 && $urandom_range(0, 3) == 0) key_pool.push_back(k);
      send_req(op, c, k);
    end
    drain();
  endtask

  initial begin
    fail_count = 0;
    beats_seen = 0;
    reqs_sent = 0;
    burst_left = 0;
    tbl_used = 0;
    foreach (tbl_cnt[i]) tbl_cnt[i] = 0;
    req_valid = 1'b0;
    req = '0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_basic_ops();
    test_full_table();
    test_random(250);
    $display("run covered %0d requests and %0d response beats, with %0d of %0d topics in use",
             reqs_sent, beats_seen, tbl_used, NSLOT);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
